// ===== design/prime_factorizer_core_macros.svh =====
// Assertion helpers shared by the checker.
`ifndef PRIME_FACTORIZER_CORE_MACROS_SVH
`define PRIME_FACTORIZER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PFC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pfc_pkg.sv =====
package pfc_pkg;

  localparam int NUMBER_BITS_DEF = 31;
  localparam int FACTOR_W        = 31;
  localparam int EXP_W           = 5;
  localparam int KIND_W          = 2;
  localparam int SLOT_COUNT      = 16;
  localparam int SLOT_IW         = 4;

  localparam logic [KIND_W-1:0] KIND_FACTOR    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PRIME     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BELOW_TWO = 2'd2;

  localparam logic [EXP_W-1:0] EXP_MAX = 5'd31;

  typedef struct packed {
    logic load;       // capture a new number
    logic div_start;  // seed the divider with the current rest
    logic div_step;   // one restoring step
    logic take_quot;  // rest <= quotient, bump exponent
    logic rec_d;      // store trial divisor and its exponent
    logic next_d;     // advance trial divisor and its square
    logic rec_rest;   // store leftover prime with exponent one
    logic slot_rd;    // fetch the slot for the next result
    logic out_slot;   // load a factor result from the fetched slot
    logic out_single; // load a prime or below-two result
  } cmd_t;

  typedef struct packed {
    logic n_lt2;
    logic sq_le_rest;
    logic rem_zero;
    logic exp_nz;
    logic rest_gt1;
    logic found;
    logic count_one;
    logic out_free;
  } status_t;

endpackage

// ===== design/pfc_datapath.sv =====
module pfc_datapath #(
  parameter int NUMBER_BITS = pfc_pkg::NUMBER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pfc_pkg::cmd_t                 cmd,
  output pfc_pkg::status_t              status,
  input  logic [NUMBER_BITS-1:0]        in_number,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pfc_pkg::KIND_W-1:0]    out_kind,
  output logic [pfc_pkg::FACTOR_W-1:0]  out_factor,
  output logic [pfc_pkg::EXP_W-1:0]     out_exponent,
  output logic                          out_last
);
  import pfc_pkg::*;

  // Trial divisor never exceeds sqrt(2^NUMBER_BITS) + 1.
  localparam int D_W  = (NUMBER_BITS + 1) / 2 + 1;
  localparam int SQ_W = 2 * D_W;

  logic [NUMBER_BITS-1:0] n_r;
  logic [NUMBER_BITS-1:0] rest_r;
  logic [D_W-1:0]         d_r;
  logic [SQ_W-1:0]        sq_r;
  logic [NUMBER_BITS-1:0] quo_r;
  logic [D_W-1:0]         rem_r;
  logic [EXP_W-1:0]       exp_r;
  logic [SLOT_IW:0]       count_r;
  logic                   found_r;

  logic [FACTOR_W-1:0] slot_fac_mem [SLOT_COUNT];
  logic [EXP_W-1:0]    slot_exp_mem [SLOT_COUNT];
  logic [FACTOR_W-1:0] rd_fac_r;
  logic [EXP_W-1:0]    rd_exp_r;

  logic                out_valid_r;
  logic [KIND_W-1:0]   out_kind_r;
  logic [FACTOR_W-1:0] out_factor_r;
  logic [EXP_W-1:0]    out_exp_r;
  logic                out_last_r;

  logic [D_W:0]         trial;
  logic                 trial_ge;
  logic [D_W:0]         trial_diff;
  logic                 slot_free;
  logic [SLOT_IW-1:0]   wr_idx;
  logic [SLOT_IW-1:0]   rd_idx;

  assign trial      = {rem_r, quo_r[NUMBER_BITS-1]};
  assign trial_ge   = trial >= {1'b0, d_r};
  assign trial_diff = trial - {1'b0, d_r};
  assign slot_free  = ~count_r[SLOT_IW];
  assign wr_idx     = count_r[SLOT_IW-1:0];
  assign rd_idx     = count_r[SLOT_IW-1:0] - SLOT_IW'(1);

  assign status.n_lt2      = n_r < NUMBER_BITS'(2);
  assign status.sq_le_rest = sq_r <= SQ_W'(rest_r);
  assign status.rem_zero   = rem_r == '0;
  assign status.exp_nz     = exp_r != '0;
  assign status.rest_gt1   = rest_r > NUMBER_BITS'(1);
  assign status.found      = found_r;
  assign status.count_one  = count_r == (SLOT_IW+1)'(1);
  assign status.out_free   = ~out_valid_r | out_ready;

  // Number, divisor and restoring divider.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r    <= in_number;
      rest_r <= in_number;
      d_r    <= D_W'(2);
      sq_r   <= SQ_W'(4);
    end else begin
      if (cmd.take_quot) rest_r <= quo_r;
      if (cmd.next_d) begin
        // (d+1)^2 = d^2 + 2d + 1
        sq_r <= sq_r + SQ_W'({d_r, 1'b1});
        d_r  <= d_r + D_W'(1);
      end
    end
    if (cmd.div_start) begin
      quo_r <= rest_r;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[NUMBER_BITS-2:0], trial_ge};
      rem_r <= trial_ge ? trial_diff[D_W-1:0] : trial[D_W-1:0];
    end
  end

  // Exponent, slot count and found flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r   <= '0;
      count_r <= '0;
      found_r <= 1'b0;
    end else if (cmd.load) begin
      exp_r   <= '0;
      count_r <= '0;
      found_r <= 1'b0;
    end else begin
      if (cmd.take_quot && exp_r != EXP_MAX) exp_r <= exp_r + EXP_W'(1);
      else if (cmd.next_d) exp_r <= '0;
      if (cmd.rec_d) found_r <= 1'b0 | 1'b1;
      if ((cmd.rec_d || cmd.rec_rest) && slot_free) count_r <= count_r + (SLOT_IW+1)'(1);
      else if (cmd.out_slot) count_r <= count_r - (SLOT_IW+1)'(1);
    end
  end

  // Factor slots, filled smallest first and drained from the top.
  always_ff @(posedge clk) begin
    if (cmd.rec_d && slot_free) begin
      slot_fac_mem[wr_idx] <= FACTOR_W'(d_r);
      slot_exp_mem[wr_idx] <= exp_r;
    end else if (cmd.rec_rest && slot_free) begin
      slot_fac_mem[wr_idx] <= FACTOR_W'(rest_r);
      slot_exp_mem[wr_idx] <= EXP_W'(1);
    end
    if (cmd.slot_rd) begin
      rd_fac_r <= slot_fac_mem[rd_idx];
      rd_exp_r <= slot_exp_mem[rd_idx];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_slot || cmd.out_single) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_slot) begin
      out_kind_r   <= KIND_FACTOR;
      out_factor_r <= rd_fac_r;
      out_exp_r    <= rd_exp_r;
      out_last_r   <= status.count_one;
    end else if (cmd.out_single) begin
      out_kind_r   <= status.n_lt2 ? KIND_BELOW_TWO : KIND_PRIME;
      out_factor_r <= status.n_lt2 ? '0 : FACTOR_W'(n_r);
      out_exp_r    <= status.n_lt2 ? '0 : EXP_W'(1);
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_factor   = out_factor_r;
  assign out_exponent = out_exp_r;
  assign out_last     = out_last_r;

endmodule

// ===== design/pfc_ctrl.sv =====
module pfc_ctrl #(
  parameter int NUMBER_BITS = pfc_pkg::NUMBER_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pfc_pkg::status_t  status,
  output pfc_pkg::cmd_t     cmd
);
  import pfc_pkg::*;

  localparam int CNT_W = $clog2(NUMBER_BITS);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CHECK     = 4'd1;
  localparam logic [3:0] S_DIV       = 4'd2;
  localparam logic [3:0] S_EVAL      = 4'd3;
  localparam logic [3:0] S_REDIV     = 4'd4;
  localparam logic [3:0] S_TAIL      = 4'd5;
  localparam logic [3:0] S_SINGLE    = 4'd6;
  localparam logic [3:0] S_EMIT_RD   = 4'd7;
  localparam logic [3:0] S_EMIT_WAIT = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      bit_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      bit_cnt_r <= bit_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    bit_cnt_nxt = bit_cnt_r;
    cmd         = '0;
    in_ready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.n_lt2) begin
          state_nxt = S_SINGLE;
        end else if (status.sq_le_rest) begin
          cmd.div_start = 1'b1;
          bit_cnt_nxt   = CNT_W'(NUMBER_BITS - 1);
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_TAIL;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (bit_cnt_r == '0) state_nxt = S_EVAL;
        else bit_cnt_nxt = bit_cnt_r - CNT_W'(1);
      end
      S_EVAL: begin
        if (status.rem_zero) begin
          cmd.take_quot = 1'b1;
          state_nxt     = S_REDIV;
        end else begin
          // divisor exhausted: keep it if it divided, then try the next one
          cmd.rec_d  = status.exp_nz;
          cmd.next_d = 1'b1;
          state_nxt  = S_CHECK;
        end
      end
      S_REDIV: begin
        cmd.div_start = 1'b1;
        bit_cnt_nxt   = CNT_W'(NUMBER_BITS - 1);
        state_nxt     = S_DIV;
      end
      S_TAIL: begin
        if (status.rest_gt1 && !status.found) begin
          state_nxt = S_SINGLE;
        end else begin
          cmd.rec_rest = status.rest_gt1;
          state_nxt    = S_EMIT_RD;
        end
      end
      S_SINGLE: begin
        if (status.out_free) begin
          cmd.out_single = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_EMIT_RD: begin
        cmd.slot_rd = 1'b1;
        state_nxt   = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (status.out_free) begin
          cmd.out_slot = 1'b1;
          state_nxt    = status.count_one ? S_IDLE : S_EMIT_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== design/prime_factorizer_core.sv =====
// Channel  | Signals                                         | Direction
// ---------+-------------------------------------------------+----------
// in       | in_valid, in_ready, in_number                   | request in
// out      | out_valid, out_ready, out_kind, out_factor,     | results out
//          | out_exponent, out_last                          |
//
// One request at a time. Each trial divisor d (2, 3, ... while d*d <= rest)
// is tried by a full division of the rest in the bit-serial restoring divider,
// and a divisor that divides is tried again on the quotient until it fails.
// When no divisor is left, results leave one at a time: each is fetched from
// its slot and then loaded into the output register once that is free.
// Reset is synchronous and clears only control state; no clearing pass.
// A stalled output holds the last result while the next request is taken.
module prime_factorizer_core #(
  parameter int NUMBER_BITS = pfc_pkg::NUMBER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [NUMBER_BITS-1:0]        in_number,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pfc_pkg::KIND_W-1:0]    out_kind,
  output logic [pfc_pkg::FACTOR_W-1:0]  out_factor,
  output logic [pfc_pkg::EXP_W-1:0]     out_exponent,
  output logic                          out_last
);
  import pfc_pkg::*;

  cmd_t    cmd;
  status_t status;

  pfc_ctrl #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pfc_datapath #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_number    (in_number),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_factor   (out_factor),
    .out_exponent (out_exponent),
    .out_last     (out_last)
  );

endmodule

// ===== design/pfc_checker.sv =====
`include "prime_factorizer_core_macros.svh"

module pfc_checker #(
  parameter int NUMBER_BITS = pfc_pkg::NUMBER_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [NUMBER_BITS-1:0]        in_number,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pfc_pkg::KIND_W-1:0]    out_kind,
  input logic [pfc_pkg::FACTOR_W-1:0]  out_factor,
  input logic [pfc_pkg::EXP_W-1:0]     out_exponent,
  input logic                          out_last
);
  import pfc_pkg::*;

  `PFC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_factor) && $stable(out_exponent) && $stable(out_last), "stalled result changed")
  `PFC_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready && in_number == in_number, !in_ready, "request taken while busy")
  `PFC_ASSERT_NOW(a_single_last, out_valid && out_kind != KIND_FACTOR, out_last, "prime or below-two result without last")
  `PFC_ASSERT_NOW(a_below_two, out_valid && out_kind == KIND_BELOW_TWO, out_factor == '0 && out_exponent == '0, "below-two result carries data")
  `PFC_ASSERT_NOW(a_factor_sane, out_valid && out_kind == KIND_FACTOR, out_exponent != '0 && out_factor > FACTOR_W'(1), "factor result out of range")

endmodule

bind prime_factorizer_core pfc_checker #(.NUMBER_BITS(NUMBER_BITS)) u_pfc_checker (.*);

// ===== tb/prime_factorizer_core_tb.sv =====
`timescale 1ns / 100ps

module prime_factorizer_core_tb;
  import pfc_pkg::*;

  localparam int NB = NUMBER_BITS_DEF;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [FACTOR_W-1:0] factor;
    logic [EXP_W-1:0]    exponent;
    logic                last;
  } factor_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [NB-1:0]       in_number;
  logic                out_valid;
  logic                out_ready;
  logic [KIND_W-1:0]   out_kind;
  logic [FACTOR_W-1:0] out_factor;
  logic [EXP_W-1:0]    out_exponent;
  logic                out_last;

  logic [NB-1:0]  pending_numbers[$];
  factor_result_t expected_factors[$];
  int             sent_count;
  int             mismatch_count;
  bit             req_taken;
  bit             calm;

  prime_factorizer_core u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_number    (in_number),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_factor   (out_factor),
    .out_exponent (out_exponent),
    .out_last     (out_last)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Trial division; push results largest factor first.
  task automatic predict_factorization(input logic [NB-1:0] number);
    longint unsigned rest;
    longint unsigned d;
    longint unsigned e;
    longint unsigned vals[$];
    longint unsigned exps[$];
    factor_result_t  r;
    begin
      rest = number;
      d    = 2;
      if (number < 2) begin
        r = '{kind: KIND_BELOW_TWO, factor: '0, exponent: '0, last: 1'b1};
        expected_factors.push_back(r);
        return;
      end
      while (d <= rest / d) begin
        if (rest % d == 0) begin
          e = 0;
          while (rest % d == 0) begin
            rest = rest / d;
            e++;
          end
          if (vals.size() < SLOT_COUNT) begin
            vals.push_back(d);
            exps.push_back(e);
          end
        end
        d++;
      end
      if (rest > 1 && vals.size() < SLOT_COUNT) begin
        vals.push_back(rest);
        exps.push_back(1);
      end
      if (vals.size() == 1 && vals[0] == number) begin
        r = '{kind: KIND_PRIME, factor: FACTOR_W'(number), exponent: EXP_W'(1), last: 1'b1};
        expected_factors.push_back(r);
        return;
      end
      for (int k = vals.size() - 1; k >= 0; k--) begin
        r.kind     = KIND_FACTOR;
        r.factor   = FACTOR_W'(vals[k]);
        r.exponent = (exps[k] > EXP_MAX) ? EXP_MAX : EXP_W'(exps[k]);
        r.last     = (k == 0);
        expected_factors.push_back(r);
      end
    end
  endtask

  assign calm = (sent_count >= 40) && (sent_count < 60);

  // Driver: hold the request until taken, then advance or idle.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || req_taken) begin
        if (pending_numbers.size() != 0 && (calm || $urandom_range(0, 99) >= 33)) begin
          in_valid  <= 1'b1;
          in_number <= pending_numbers.pop_front();
          sent_count++;
        end else begin
          in_valid <= 1'b0;
        end
      end
      req_taken = 1'b0;
      out_ready <= calm || ($urandom_range(0, 99) >= 33);
    end
  end

  // Monitor: predict on each taken request, check each result.
  always @(posedge clk) begin
    factor_result_t want;
    factor_result_t got;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_factorization(in_number);
        req_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        got = '{kind: out_kind, factor: out_factor, exponent: out_exponent, last: out_last};
        if (expected_factors.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result kind=%0d factor=%0d exp=%0d last=%0d",
                   $time, got.kind, got.factor, got.exponent, got.last);
        end else begin
          want = expected_factors.pop_front();
          if (got.kind !== want.kind || got.factor !== want.factor ||
              got.exponent !== want.exponent || got.last !== want.last) begin
            mismatch_count++;
            $display("%0t: mismatch expected kind=%0d factor=%0d exp=%0d last=%0d",
                     $time, want.kind, want.factor, want.exponent, want.last);
            $display("%0t:          actual   kind=%0d factor=%0d exp=%0d last=%0d",
                     $time, got.kind, got.factor, got.exponent, got.last);
          end
        end
      end
    end
  end

  initial begin
    int              small_primes[15];
    longint unsigned value;
    int              pick;
    int              p;
    small_primes = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47};
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_number      = '0;
    out_ready      = 1'b0;
    sent_count     = 0;
    mismatch_count = 0;
    req_taken      = 1'b0;

    // below two, tiny primes and composites
    pending_numbers.push_back(NB'(0));
    pending_numbers.push_back(NB'(1));
    pending_numbers.push_back(NB'(2));
    pending_numbers.push_back(NB'(3));
    pending_numbers.push_back(NB'(4));
    pending_numbers.push_back(NB'(6));
    pending_numbers.push_back(NB'(8));
    pending_numbers.push_back(NB'(9));
    pending_numbers.push_back(NB'(12));
    pending_numbers.push_back(NB'(49));
    pending_numbers.push_back(NB'(97));
    pending_numbers.push_back(NB'(1024));
    pending_numbers.push_back(NB'(65521));
    pending_numbers.push_back(NB'(131042));
    pending_numbers.push_back(NB'(999983));
    // highest exponent, most distinct factors, top bits set
    pending_numbers.push_back(NB'(1073741824));
    pending_numbers.push_back(NB'(1162261467));
    pending_numbers.push_back(NB'(223092870));
    pending_numbers.push_back(NB'(2147483646));
    pending_numbers.push_back(NB'(1610612736));

    repeat (100) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        value = $urandom_range(0, 4095);
      end else if (pick < 70) begin
        value = $urandom_range(4096, 262143);
      end else if (pick < 85) begin
        // smooth number: cheap to factor, reaches the top bits
        value = 1;
        repeat ($urandom_range(1, 40)) begin
          p = small_primes[$urandom_range(0, 14)];
          if (value * p < (64'd1 << NB)) value = value * p;
        end
      end else begin
        value = longint'($urandom_range(1, 4095)) << $urandom_range(0, 19);
      end
      pending_numbers.push_back(NB'(value));
    end

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    while (pending_numbers.size() != 0 || in_valid) @(posedge clk);
    while (expected_factors.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    if (mismatch_count == 0 && expected_factors.size() == 0) begin
      $display("** prime_factorizer_core: PASSED **");
    end else begin
      $display("** prime_factorizer_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("%0t: timeout, %0d results still expected", $time, expected_factors.size());
    $display("** prime_factorizer_core: FAILED **");
    $finish;
  end

endmodule

// ===== prime_factorizer_core.f =====
+incdir+design
design/pfc_pkg.sv
design/pfc_datapath.sv
design/pfc_ctrl.sv
design/prime_factorizer_core.sv
design/pfc_checker.sv
tb/prime_factorizer_core_tb.sv
